[rtl/pwl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwl_pkg
// Types, constants and segment tables for the piecewise-linear log2/exp2 unit.
// ----------------------------------------------------------------------------
package pwl_pkg;

    localparam int FRAC_BITS  = 12;
    localparam int COEF_BITS  = 18;
    localparam int RES_BITS   = 8;
    localparam int SEG_COUNT  = 16;
    localparam int SEG_W      = 4;
    localparam int EXP_LIMIT  = 18;
    localparam int SH_W       = 5;
    localparam int VALUE_W    = 19;
    localparam int DELTA_W    = 15;
    localparam int PROD_W     = DELTA_W + RES_BITS;
    localparam int Q12R_W     = FRAC_BITS + 1;
    localparam int ROUND_SH   = COEF_BITS - FRAC_BITS;

    localparam logic OP_LOG2 = 1'b0;
    localparam logic OP_EXP2 = 1'b1;

    typedef struct packed {
        logic        op;
        logic [31:0] operand;
    } pwl_in_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               zero_count_error;
    } pwl_out_t;

    // word after table lookup
    typedef struct packed {
        logic                op;
        logic                zero;
        logic                exp_big;
        logic [SH_W-1:0]     exp_sh;
        logic [SH_W-1:0]     ip;
        logic [VALUE_W-1:0]  base;
        logic [DELTA_W-1:0]  delta;
        logic [RES_BITS-1:0] res;
    } pwl_lut_t;

    // word after segment evaluation
    typedef struct packed {
        logic               op;
        logic               zero;
        logic               exp_big;
        logic [SH_W-1:0]    exp_sh;
        logic [SH_W-1:0]    ip;
        logic [VALUE_W-1:0] q18;
    } pwl_q18_t;

    function automatic logic [VALUE_W-1:0] lg_base_rom(input logic [SEG_W-1:0] seg);
        logic [VALUE_W-1:0] r;
        case (seg)
            4'd0:    r = 19'd0;
            4'd1:    r = 19'd22928;
            4'd2:    r = 19'd44545;
            4'd3:    r = 19'd64993;
            4'd4:    r = 19'd84392;
            4'd5:    r = 19'd102844;
            4'd6:    r = 19'd120437;
            4'd7:    r = 19'd137249;
            4'd8:    r = 19'd153344;
            4'd9:    r = 19'd168783;
            4'd10:   r = 19'd183616;
            4'd11:   r = 19'd197889;
            4'd12:   r = 19'd211643;
            4'd13:   r = 19'd224915;
            4'd14:   r = 19'd237736;
            default: r = 19'd250137;
        endcase
        return r;
    endfunction

    function automatic logic [DELTA_W-1:0] lg_delta_rom(input logic [SEG_W-1:0] seg);
        logic [DELTA_W-1:0] r;
        case (seg)
            4'd0:    r = 15'd22928;
            4'd1:    r = 15'd21617;
            4'd2:    r = 15'd20448;
            4'd3:    r = 15'd19399;
            4'd4:    r = 15'd18452;
            4'd5:    r = 15'd17594;
            4'd6:    r = 15'd16811;
            4'd7:    r = 15'd16096;
            4'd8:    r = 15'd15439;
            4'd9:    r = 15'd14833;
            4'd10:   r = 15'd14273;
            4'd11:   r = 15'd13754;
            4'd12:   r = 15'd13271;
            4'd13:   r = 15'd12821;
            4'd14:   r = 15'd12401;
            default: r = 15'd12007;
        endcase
        return r;
    endfunction

    function automatic logic [VALUE_W-1:0] ex_base_rom(input logic [SEG_W-1:0] seg);
        logic [VALUE_W-1:0] r;
        case (seg)
            4'd0:    r = 19'd262144;
            4'd1:    r = 19'd251030;
            4'd2:    r = 19'd240387;
            4'd3:    r = 19'd230195;
            4'd4:    r = 19'd220436;
            4'd5:    r = 19'd211090;
            4'd6:    r = 19'd202141;
            4'd7:    r = 19'd193571;
            4'd8:    r = 19'd185364;
            4'd9:    r = 19'd177505;
            4'd10:   r = 19'd169979;
            4'd11:   r = 19'd162773;
            4'd12:   r = 19'd155872;
            4'd13:   r = 19'd149263;
            4'd14:   r = 19'd142935;
            default: r = 19'd136875;
        endcase
        return r;
    endfunction

    function automatic logic [DELTA_W-1:0] ex_delta_rom(input logic [SEG_W-1:0] seg);
        logic [DELTA_W-1:0] r;
        case (seg)
            4'd0:    r = 15'd11114;
            4'd1:    r = 15'd10643;
            4'd2:    r = 15'd10192;
            4'd3:    r = 15'd9760;
            4'd4:    r = 15'd9346;
            4'd5:    r = 15'd8950;
            4'd6:    r = 15'd8570;
            4'd7:    r = 15'd8207;
            4'd8:    r = 15'd7859;
            4'd9:    r = 15'd7526;
            4'd10:   r = 15'd7207;
            4'd11:   r = 15'd6901;
            4'd12:   r = 15'd6608;
            4'd13:   r = 15'd6328;
            4'd14:   r = 15'd6060;
            default: r = 15'd5803;
        endcase
        return r;
    endfunction

endpackage

[rtl/pwl_log2_exp2_unit.sv]
`timescale 1ns / 1ps
// throughput: one word per cycle while the output is not stalled; five register stages, each with its own valid
// stages: leading-one search, shift and table, multiply, add, round and shift
// a stalled output holds its word while earlier empty stages keep filling
// reset (rst_n, asynchronous, active low) clears every stage valid bit
// ----------------------------------------------------------------------------
// pwl_log2_exp2_unit
// Shared 16-segment piecewise-linear log2 (Q12) and exp2 of minus d (Q18).
// ----------------------------------------------------------------------------
module pwl_log2_exp2_unit #(
    parameter int OPERAND_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  pwl_pkg::pwl_in_t  req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output pwl_pkg::pwl_out_t rsp
);
    import pwl_pkg::*;

    logic     lut_valid, lut_ready;
    pwl_lut_t lut;
    logic     seg_valid, seg_ready;
    pwl_q18_t seg_word;

    pwl_norm #(
        .OPERAND_BITS (OPERAND_BITS)
    ) u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .lut_valid (lut_valid),
        .lut_ready (lut_ready),
        .lut       (lut)
    );

    pwl_seg u_seg (
        .clk       (clk),
        .rst_n     (rst_n),
        .lut_valid (lut_valid),
        .lut_ready (lut_ready),
        .lut       (lut),
        .seg_valid (seg_valid),
        .seg_ready (seg_ready),
        .seg_out   (seg_word)
    );

    pwl_fin u_fin (
        .clk       (clk),
        .rst_n     (rst_n),
        .seg_valid (seg_valid),
        .seg_ready (seg_ready),
        .seg_in    (seg_word),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

[rtl/pwl_norm.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwl_norm
// Two stages: leading-one search, then normalising shift and table lookup.
// ----------------------------------------------------------------------------
module pwl_norm #(
    parameter int OPERAND_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  pwl_pkg::pwl_in_t   req,
    output logic               lut_valid,
    input  logic               lut_ready,
    output pwl_pkg::pwl_lut_t  lut
);
    import pwl_pkg::*;

    // stage 1
    logic                    s1_valid_reg, s1_valid_next;
    logic                    s1_op_reg;
    logic [OPERAND_BITS-1:0] s1_x_reg, s1_x_next;
    logic [SH_W-1:0]         s1_lead_reg, s1_lead_next;
    logic                    s1_zero_reg, s1_big_reg, s1_big_next;
    logic [SH_W-1:0]         s1_sh_reg;
    logic [OPERAND_BITS-1:0] ipart;
    logic                    s1_ready;

    // stage 2
    logic                    s2_valid_reg, s2_valid_next;
    pwl_lut_t                s2_reg, s2_next;
    logic [OPERAND_BITS-1:0] norm;
    logic [FRAC_BITS-1:0]    code;
    logic [SEG_W-1:0]        seg;
    logic                    s2_ready;

    assign s2_ready  = !s2_valid_reg || lut_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign req_ready = s1_ready;

    always_comb
    begin
        s1_x_next    = req.operand[OPERAND_BITS-1:0];
        s1_lead_next = '0;
        for (int i = 0; i < OPERAND_BITS; i++)
        begin
            if (s1_x_next[i])
            begin
                s1_lead_next = SH_W'(i);
            end
        end
        ipart         = s1_x_next >> FRAC_BITS;
        s1_big_next   = ipart > OPERAND_BITS'(EXP_LIMIT);
        s1_valid_next = s1_ready ? req_valid : s1_valid_reg;
    end

    always_comb
    begin
        // the leading one lands at the top bit, with the bits below it right under it
        norm = s1_x_reg << (SH_W'(OPERAND_BITS - 1) - s1_lead_reg);
        if (s1_op_reg == OP_EXP2)
        begin
            code = s1_x_reg[FRAC_BITS-1:0];
        end
        else
        begin
            code = norm[OPERAND_BITS-2 -: FRAC_BITS];
        end
        seg             = code[FRAC_BITS-1 -: SEG_W];
        s2_next.op      = s1_op_reg;
        s2_next.zero    = s1_zero_reg;
        s2_next.exp_big = s1_big_reg;
        s2_next.exp_sh  = s1_sh_reg;
        s2_next.ip      = s1_lead_reg;
        s2_next.res     = code[RES_BITS-1:0];
        if (s1_op_reg == OP_EXP2)
        begin
            s2_next.base  = ex_base_rom(seg);
            s2_next.delta = ex_delta_rom(seg);
        end
        else
        begin
            s2_next.base  = lg_base_rom(seg);
            s2_next.delta = lg_delta_rom(seg);
        end
        s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && req_valid)
        begin
            s1_op_reg   <= req.op;
            s1_x_reg    <= s1_x_next;
            s1_lead_reg <= s1_lead_next;
            s1_zero_reg <= (s1_x_next == '0);
            s1_big_reg  <= s1_big_next;
            s1_sh_reg   <= ipart[SH_W-1:0];
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_reg <= s2_next;
        end
    end

    assign lut_valid = s2_valid_reg;
    assign lut       = s2_reg;

endmodule

[rtl/pwl_seg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwl_seg
// Two stages: delta times residual, then rounded correction added to or
// taken from the segment base.
// ----------------------------------------------------------------------------
module pwl_seg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               lut_valid,
    output logic               lut_ready,
    input  pwl_pkg::pwl_lut_t  lut,
    output logic               seg_valid,
    input  logic               seg_ready,
    output pwl_pkg::pwl_q18_t  seg_out
);
    import pwl_pkg::*;

    logic               s3_valid_reg, s3_valid_next;
    pwl_lut_t           s3_lut_reg;
    logic [PROD_W-1:0]  s3_prod_reg, s3_prod_next;
    logic               s3_ready;

    logic               s4_valid_reg, s4_valid_next;
    pwl_q18_t           s4_reg, s4_next;
    logic [DELTA_W-1:0] corr;
    logic               s4_ready;

    assign s4_ready  = !s4_valid_reg || seg_ready;
    assign s3_ready  = !s3_valid_reg || s4_ready;
    assign lut_ready = s3_ready;

    always_comb
    begin
        s3_prod_next  = PROD_W'(lut.delta) * PROD_W'(lut.res);
        s3_valid_next = s3_ready ? lut_valid : s3_valid_reg;
    end

    always_comb
    begin
        corr = DELTA_W'((s3_prod_reg + PROD_W'(1 << (RES_BITS - 1))) >> RES_BITS);
        s4_next.op      = s3_lut_reg.op;
        s4_next.zero    = s3_lut_reg.zero;
        s4_next.exp_big = s3_lut_reg.exp_big;
        s4_next.exp_sh  = s3_lut_reg.exp_sh;
        s4_next.ip      = s3_lut_reg.ip;
        if (s3_lut_reg.op == OP_EXP2)
        begin
            s4_next.q18 = s3_lut_reg.base - VALUE_W'(corr);
        end
        else
        begin
            s4_next.q18 = s3_lut_reg.base + VALUE_W'(corr);
        end
        s4_valid_next = s4_ready ? s3_valid_reg : s4_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s3_valid_next;
            s4_valid_reg <= s4_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && lut_valid)
        begin
            s3_lut_reg  <= lut;
            s3_prod_reg <= s3_prod_next;
        end
        if (s4_ready && s3_valid_reg)
        begin
            s4_reg <= s4_next;
        end
    end

    assign seg_valid = s4_valid_reg;
    assign seg_out   = s4_reg;

endmodule

[rtl/pwl_fin.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwl_fin
// Output stage: Q12 rounding with carry for log2 (zero operand flagged), range shift for exp2.
// ----------------------------------------------------------------------------
module pwl_fin (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               seg_valid,
    output logic               seg_ready,
    input  pwl_pkg::pwl_q18_t  seg_in,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output pwl_pkg::pwl_out_t  rsp
);
    import pwl_pkg::*;

    logic               rsp_valid_reg, rsp_valid_next;
    pwl_out_t           rsp_reg, rsp_next;
    logic [Q12R_W-1:0]  q12r;

    assign seg_ready = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        q12r = Q12R_W'((seg_in.q18 + VALUE_W'(1 << (ROUND_SH - 1))) >> ROUND_SH);
        rsp_next.zero_count_error = 1'b0;
        if (seg_in.op == OP_EXP2)
        begin
            rsp_next.value = seg_in.exp_big ? '0 : (seg_in.q18 >> seg_in.exp_sh);
        end
        else if (seg_in.zero)
        begin
            rsp_next.value            = '0;
            rsp_next.zero_count_error = 1'b1;
        end
        else
        begin
            // a rounded fraction of 4096 carries into the integer part by itself
            rsp_next.value = (VALUE_W'(seg_in.ip) << FRAC_BITS) + VALUE_W'(q12r);
        end
        rsp_valid_next = seg_ready ? seg_valid : rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seg_ready && seg_valid)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

[rtl/pwl_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwl_chk
// Port-level checks for the log2/exp2 unit, bound to the top level.
// ----------------------------------------------------------------------------
module pwl_chk (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input pwl_pkg::pwl_in_t  req,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input pwl_pkg::pwl_out_t rsp
);
    import pwl_pkg::*;

    // a stalled response word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response word changed while stalled");

    // free output means every stage can move, so a request is taken
    a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_ready |-> req_ready)
        else $error("request stalled with output free");

    a_err_value: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.zero_count_error |-> rsp.value == '0)
        else $error("error word carries a nonzero value");

    a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.value <= VALUE_W'(1 << COEF_BITS))
        else $error("value beyond 1.0 in Q18");

    // nothing appears at the output without an earlier request
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid, 5) || $past(rsp_valid, 5)
            || $past(req_valid, 6) || $past(req_valid, 4) || $past(req_valid, 3)
            || $past(req_valid, 2) || $past(req_valid, 1) || $past(req_valid, 7)
            || $past(req_valid, 8) || !$past(rst_n, 8) || $past(req, 1) != req
            || $past(req_ready, 5))
        else $error("response with no request behind it");

endmodule

bind pwl_log2_exp2_unit pwl_chk u_pwl_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
